// ===== src/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by ultrasonic_echo_ranger.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    // Ticks of 0.5 us per centimetre of range (58 us per cm round trip).
    localparam int unsigned TICKS_PER_CM = 116;
    localparam int unsigned REM_W        = 7;
    localparam int unsigned DIST_W       = 10;
    localparam int unsigned COUNT_W      = 16;
    localparam int unsigned TRIG_W       = 8;

    localparam logic [REM_W-1:0]   REM_LAST  = REM_W'(TICKS_PER_CM - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_HIGH = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        CFG_TRIGGER_TICKS   = 2'd0,
        CFG_TIMEOUT_TICKS   = 2'd1,
        CFG_MAX_DISTANCE_CM = 2'd2,
        CFG_CRIT_RANGE_CM   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              front_critical;
        logic              timed_out;
        logic [DIST_W-1:0] distance_cm;
        logic              done_res;
        logic              busy_res;
        logic              trigger;
    } t_result;

endpackage

`default_nettype wire

// ===== src/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: trigger pulse generation, echo timing and distance report.
// Depends on uer_pkg for the phase type, register indexes and widths.
`timescale 1ns / 1ps
`default_nettype none

// One input word is one 0.5 us timer tick carrying a start request and the sampled
// echo level; every accepted word yields exactly one result word. A start while idle
// drives trigger high for trigger_ticks ticks (0 acts as 1), then the block waits for
// echo to rise and counts high ticks. On the first low sample it reports
// floor(width / 116) cm; if timeout_ticks ticks pass after the trigger ends first,
// it reports max_distance_cm with timed_out set. Distance and timeout are held
// between measurements; front_critical compares the held distance against the
// current critical range register. Rate: one word per clock cycle. The whole tick
// update is a combinational state step feeding one output register; the input side
// stalls only while that register holds a word that the master side has not taken.
// The distance is kept as a running quotient and remainder alongside the width
// count, so no divider sits in the path. Configuration words are always taken
// (o_cfg_ready is tied high) and must be written while the block is idle.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Input ticks. tdata from bit 0: start_req, echo, zero fill.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,

    // Results. tdata from bit 0: trigger, busy_res, done_res, distance_cm[9:0],
    // timed_out, front_critical, zero fill.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,

    // Register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [TRIG_W-1:0]  r_trigger_ticks;
    logic [COUNT_W-1:0] r_timeout_ticks;
    logic [DIST_W-1:0]  r_max_distance_cm;
    logic [DIST_W-1:0]  r_crit_range_cm;

    // Measurement state
    t_phase             r_phase,         n_phase;
    logic [TRIG_W-1:0]  r_trigger_count, n_trigger_count;
    logic [COUNT_W-1:0] r_wait_count,    n_wait_count;
    logic [COUNT_W-1:0] r_high_width,    n_high_width;
    logic [DIST_W-1:0]  r_quot,          n_quot;     // high_width / 116
    logic [REM_W-1:0]   r_rem,           n_rem;      // high_width % 116
    logic [DIST_W-1:0]  r_last_distance, n_last_distance;
    logic               r_last_timeout,  n_last_timeout;

    // Output register
    logic               r_out_valid;
    t_result            r_out,           n_out;

    logic               s_accept;
    logic               in_start;
    logic               in_echo;

    assign in_start      = s_axis_tdata[0];
    assign in_echo       = s_axis_tdata[1];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // One tick of the measurement sequencer
    always_comb begin
        t_phase            ph;
        logic [TRIG_W-1:0] tc;
        logic [TRIG_W-1:0] tlen;
        logic              trig;
        logic              done;

        ph              = r_phase;
        tc              = r_trigger_count;
        tlen            = (r_trigger_ticks == '0) ? TRIG_W'(1) : r_trigger_ticks;
        trig            = 1'b0;
        done            = 1'b0;
        n_wait_count    = r_wait_count;
        n_high_width    = r_high_width;
        n_quot          = r_quot;
        n_rem           = r_rem;
        n_last_distance = r_last_distance;
        n_last_timeout  = r_last_timeout;

        // Start while idle: this tick is already the first trigger tick
        if (ph == PH_IDLE && in_start) begin
            ph = PH_TRIG;
            tc = '0;
        end

        case (ph)
            PH_TRIG: begin
                trig = 1'b1;
                tc   = tc + TRIG_W'(1);
                if (tc >= tlen || tc == '0) begin
                    ph           = PH_WAIT;
                    n_wait_count = '0;
                    n_high_width = '0;
                    n_quot       = '0;
                    n_rem        = '0;
                end
            end
            PH_WAIT, PH_HIGH: begin
                if (ph == PH_HIGH && !in_echo) begin
                    // Falling edge wins over a timeout on the same tick
                    n_last_distance = r_quot;
                    n_last_timeout  = 1'b0;
                    ph              = PH_IDLE;
                    done            = 1'b1;
                end else begin
                    if (in_echo) begin
                        ph = PH_HIGH;
                        if (r_high_width != COUNT_MAX) begin
                            n_high_width = r_high_width + COUNT_W'(1);
                            if (r_rem == REM_LAST) begin
                                n_rem  = '0;
                                n_quot = r_quot + DIST_W'(1);
                            end else begin
                                n_rem  = r_rem + REM_W'(1);
                            end
                        end
                    end
                    if (r_wait_count != COUNT_MAX) begin
                        n_wait_count = r_wait_count + COUNT_W'(1);
                    end
                    if (n_wait_count >= r_timeout_ticks) begin
                        n_last_distance = r_max_distance_cm;
                        n_last_timeout  = 1'b1;
                        ph              = PH_IDLE;
                        done            = 1'b1;
                    end
                end
            end
            default: begin
                // idle without a start: hold everything
            end
        endcase

        n_phase         = ph;
        n_trigger_count = tc;

        n_out.trigger        = trig;
        n_out.busy_res       = (ph != PH_IDLE);
        n_out.done_res       = done;
        n_out.distance_cm    = n_last_distance;
        n_out.timed_out      = n_last_timeout;
        n_out.front_critical = (n_last_distance != '0) &&
                               (n_last_distance <= r_crit_range_cm);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks   <= TRIG_W'(20);
            r_timeout_ticks   <= COUNT_W'(60000);
            r_max_distance_cm <= DIST_W'(400);
            r_crit_range_cm   <= DIST_W'(20);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TRIGGER_TICKS:   r_trigger_ticks   <= i_cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT_TICKS:   r_timeout_ticks   <= i_cfg_data;
                CFG_MAX_DISTANCE_CM: r_max_distance_cm <= i_cfg_data[DIST_W-1:0];
                CFG_CRIT_RANGE_CM:   r_crit_range_cm   <= i_cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Advance state on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_trigger_count <= '0;
            r_wait_count    <= '0;
            r_high_width    <= '0;
            r_quot          <= '0;
            r_rem           <= '0;
            r_last_distance <= '0;
            r_last_timeout  <= 1'b0;
        end else if (s_accept) begin
            r_phase         <= n_phase;
            r_trigger_count <= n_trigger_count;
            r_wait_count    <= n_wait_count;
            r_high_width    <= n_high_width;
            r_quot          <= n_quot;
            r_rem           <= n_rem;
            r_last_distance <= n_last_distance;
            r_last_timeout  <= n_last_timeout;
        end
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

    // A start taken while idle shows the trigger high in the loaded result
    a_start_triggers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_phase == PH_IDLE && in_start) |=> r_out.trigger)
        else $error("start while idle did not raise trigger");

    // A completing tick always returns the sequencer to idle
    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && n_out.done_res) |=> (r_phase == PH_IDLE && !r_out.busy_res))
        else $error("measurement completed but sequencer not idle");

    // Width count, quotient and remainder are all cleared when the trigger ends and waiting begins
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_phase == PH_TRIG && n_phase == PH_WAIT)
            |=> (r_rem == '0 && r_quot == '0 && r_high_width == '0))
        else $error("width quotient not cleared at start of wait");

endmodule

`default_nettype wire
